FILE: hw/rtl/dttri_pkg.sv
`timescale 1ns / 1ps
package dttri_pkg;

  // accumulator and exponent widths
  localparam int ACC_WIDTH = 64;
  localparam int EXP_WIDTH = 16;

  // signed sum of decimal exponent and exponent digits
  localparam int EW = EXP_WIDTH + 2;

  // the divide-by-ten unit walks the work register 16 bits at a time
  localparam int CHUNK = 16;
  localparam int NCH = (ACC_WIDTH + CHUNK - 1) / CHUNK;
  localparam int PW = NCH * CHUNK;
  localparam int CHUNK_W = (NCH > 1) ? $clog2(NCH) : 1;

  // scaling step count: up to 9 multiply steps or 19 divide steps
  localparam int CNT_W = 5;

  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};
  localparam logic [ACC_WIDTH-1:0] MANT_ROOM = (ACC_MAX - ACC_WIDTH'(9)) / ACC_WIDTH'(10);
  localparam logic [EXP_WIDTH-1:0] EXPD_MAX = {EXP_WIDTH{1'b1}};
  localparam logic [EXP_WIDTH-1:0] DEXP_MAX = {1'b0, {(EXP_WIDTH-1){1'b1}}};
  localparam logic [EXP_WIDTH-1:0] DEXP_MIN = {1'b1, {(EXP_WIDTH-1){1'b0}}};
  localparam logic [31:0] MAG_LIMIT = 32'h7FFF_FFFF;

  // x / 10 == (x * DIV10_RECIP) >> DIV10_SHIFT for x below 2^22
  localparam logic [19:0] DIV10_RECIP = 20'd838861;
  localparam int DIV10_SHIFT = 23;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_E_LO = 8'h65;
  localparam logic [7:0] CH_E_UP = 8'h45;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INT,
    ST_FRAC,
    ST_EXP0,
    ST_EXP1,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_ROUND
  } state_e;

  typedef struct packed {
    logic clear;
    logic set_neg;
    logic take_int;
    logic take_frac;
    logic exp_sign;
    logic take_exp;
    logic prep;
    logic mul_step;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_dot;
    logic is_exp;
    logic is_plus;
    logic is_minus;
    logic run_mul;
    logic run_div;
    logic w_over;
    logic cnt_last;
    logic chunk_last;
  } sts_t;

endpackage

FILE: hw/rtl/dttri_ctrl.sv
`timescale 1ns / 1ps
module dttri_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            start_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  dttri_pkg::sts_t sts_i,
  output dttri_pkg::cmd_t cmd_o
);
  import dttri_pkg::*;

  state_e st_q, st_d;
  state_e phase_eff;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  logic   out_free;

  assign in_ready_o = (st_q inside {ST_IDLE, ST_INT, ST_FRAC, ST_EXP0, ST_EXP1});
  assign in_fire = in_valid_i & in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign phase_eff = start_req_i ? ST_INT : st_q;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE, ST_INT, ST_FRAC, ST_EXP0, ST_EXP1: begin
        if (in_fire) begin
          if (start_req_i && (sts_i.is_minus || sts_i.is_plus)) begin
            st_d = ST_INT;
          end else begin
            case (phase_eff)
              ST_INT: begin
                if (sts_i.is_digit) st_d = ST_INT;
                else if (sts_i.is_dot) st_d = ST_FRAC;
                else if (sts_i.is_exp) st_d = ST_EXP0;
                else st_d = ST_PREP;
              end
              ST_FRAC: begin
                if (sts_i.is_digit) st_d = ST_FRAC;
                else if (sts_i.is_exp) st_d = ST_EXP0;
                else st_d = ST_PREP;
              end
              ST_EXP0: begin
                if (sts_i.is_plus || sts_i.is_minus || sts_i.is_digit) st_d = ST_EXP1;
                else st_d = ST_PREP;
              end
              ST_EXP1: begin
                if (sts_i.is_digit) st_d = ST_EXP1;
                else st_d = ST_PREP;
              end
              default: st_d = st_q;
            endcase
          end
        end
      end
      ST_PREP: begin
        if (sts_i.run_mul) st_d = ST_MUL;
        else if (sts_i.run_div) st_d = ST_DIV;
        else st_d = ST_ROUND;
      end
      ST_MUL: begin
        if (sts_i.w_over || sts_i.cnt_last) st_d = ST_ROUND;
      end
      ST_DIV: begin
        if (sts_i.chunk_last && sts_i.cnt_last) st_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (out_free) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o = '0;
    case (st_q)
      ST_IDLE, ST_INT, ST_FRAC, ST_EXP0, ST_EXP1: begin
        if (in_fire) begin
          cmd_o.clear = start_req_i;
          if (start_req_i && sts_i.is_minus) begin
            cmd_o.set_neg = 1'b1;
          end else if (!(start_req_i && sts_i.is_plus)) begin
            case (phase_eff)
              ST_INT:  cmd_o.take_int = sts_i.is_digit;
              ST_FRAC: cmd_o.take_frac = sts_i.is_digit;
              ST_EXP0: begin
                cmd_o.exp_sign = sts_i.is_plus || sts_i.is_minus;
                cmd_o.take_exp = sts_i.is_digit;
              end
              ST_EXP1: cmd_o.take_exp = sts_i.is_digit;
              default: cmd_o = '0;
            endcase
          end
        end
      end
      ST_PREP:  cmd_o.prep = 1'b1;
      ST_MUL:   cmd_o.mul_step = !sts_i.w_over;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_ROUND: cmd_o.finish = out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.finish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  // scaling only starts from a terminating character transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_PREP) |-> $past(in_fire))
    else $error("scaling started without a terminating transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_ROUND && out_free) |=> (out_valid_q && st_q == ST_IDLE))
    else $error("finished result not presented");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.take_int, cmd_o.take_frac, cmd_o.take_exp, cmd_o.prep,
              cmd_o.mul_step, cmd_o.div_step, cmd_o.finish}))
    else $error("conflicting datapath commands");

endmodule

FILE: hw/rtl/dttri_dp.sv
`timescale 1ns / 1ps
module dttri_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         ch_i,
  input  dttri_pkg::cmd_t    cmd_i,
  output dttri_pkg::sts_t    sts_o,
  output logic signed [31:0] value_o,
  output logic               saturated_o
);
  import dttri_pkg::*;

  // number being parsed
  logic                 neg_q, neg_d;
  logic [ACC_WIDTH-1:0] mant_q, mant_d;
  logic [EXP_WIDTH-1:0] dexp_q, dexp_d;
  logic                 eneg_q, eneg_d;
  logic [EXP_WIDTH-1:0] ed_q, ed_d;
  logic [3:0]           rdig_q, rdig_d;
  logic                 stk_q, stk_d;
  logic                 drop_q, drop_d;

  // scaling work registers
  logic [PW-1:0]        w_q, w_d;
  logic [3:0]           wrd_q, wrd_d;
  logic                 wst_q, wst_d;
  logic [3:0]           rem_q, rem_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CHUNK_W-1:0]   chunk_q, chunk_d;
  logic                 sat_q, sat_d;

  // result register
  logic [31:0]          val_q;
  logic                 satout_q;

  logic [3:0]           digit;
  logic [EW-1:0]        e_sum;
  logic [EW-1:0]        e_mag;
  logic                 e_neg;
  logic                 e_zero;
  logic                 e_big;
  logic                 e_tiny;
  logic                 mant_zero;
  logic                 chunk_first;

  logic [19:0]          dx;
  logic [39:0]          dprod;
  logic [15:0]          dq;
  logic [19:0]          dq10;
  logic [19:0]          drem;

  logic                 inc;
  logic [32:0]          mag_p;
  logic                 sat_f;
  logic [31:0]          mag;

  assign digit = ch_i[3:0];

  assign sts_o.is_digit = ch_i inside {[CH_ZERO:CH_NINE]};
  assign sts_o.is_dot = (ch_i == CH_DOT);
  assign sts_o.is_exp = (ch_i == CH_E_LO) || (ch_i == CH_E_UP);
  assign sts_o.is_plus = (ch_i == CH_PLUS);
  assign sts_o.is_minus = (ch_i == CH_MINUS);

  // total power of ten, classified for the scaling path
  assign e_sum = eneg_q ? ({{2{dexp_q[EXP_WIDTH-1]}}, dexp_q} - {2'b00, ed_q})
                        : ({{2{dexp_q[EXP_WIDTH-1]}}, dexp_q} + {2'b00, ed_q});
  assign e_neg = e_sum[EW-1];
  assign e_mag = e_neg ? (EW'(0) - e_sum) : e_sum;
  assign e_zero = (e_sum == EW'(0));
  assign e_big = !e_neg && (e_sum > EW'(9));
  assign e_tiny = e_neg && (e_mag > EW'(19));
  assign mant_zero = (mant_q == '0);

  assign sts_o.run_mul = !mant_zero && !e_neg && !e_zero && !e_big;
  assign sts_o.run_div = !mant_zero && e_neg && !e_tiny;
  assign sts_o.w_over = (w_q > PW'(MAG_LIMIT));
  assign sts_o.cnt_last = (cnt_q == CNT_W'(1));
  assign sts_o.chunk_last = (chunk_q == CHUNK_W'(NCH - 1));

  // one 16-bit slice of the divide by ten
  assign chunk_first = (chunk_q == '0);
  assign dx = {(chunk_first ? 4'd0 : rem_q), w_q[PW-1 -: CHUNK]};
  assign dprod = {20'd0, dx} * {20'd0, DIV10_RECIP};
  assign dq = dprod[DIV10_SHIFT +: CHUNK];
  assign dq10 = ({4'd0, dq} << 3) + ({4'd0, dq} << 1);
  assign drem = dx - dq10;

  // round the magnitude up only when above one half (ties round down), then clamp
  assign inc = (wrd_q > 4'd5) || ((wrd_q == 4'd5) && wst_q);
  assign mag_p = {1'b0, w_q[31:0]} + {32'd0, inc};
  assign sat_f = sat_q || sts_o.w_over || (mag_p > {1'b0, MAG_LIMIT});
  assign mag = sat_f ? MAG_LIMIT : mag_p[31:0];

  always_comb begin
    logic                 clr;
    logic                 fits;
    logic [EXP_WIDTH+3:0] ed10;

    clr = cmd_i.clear || cmd_i.finish;
    neg_d  = clr ? 1'b0 : neg_q;
    mant_d = clr ? '0 : mant_q;
    dexp_d = clr ? '0 : dexp_q;
    eneg_d = clr ? 1'b0 : eneg_q;
    ed_d   = clr ? '0 : ed_q;
    rdig_d = clr ? 4'd0 : rdig_q;
    stk_d  = clr ? 1'b0 : stk_q;
    drop_d = clr ? 1'b0 : drop_q;

    w_d = w_q;
    wrd_d = wrd_q;
    wst_d = wst_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    chunk_d = chunk_q;
    sat_d = sat_q;

    fits = (mant_d <= MANT_ROOM);
    ed10 = ({4'd0, ed_d} << 3) + ({4'd0, ed_d} << 1) + (EXP_WIDTH + 4)'(digit);

    if (cmd_i.set_neg) neg_d = 1'b1;

    if (cmd_i.take_int || cmd_i.take_frac) begin
      if (fits) begin
        mant_d = (mant_d << 3) + (mant_d << 1) + ACC_WIDTH'(digit);
        if (cmd_i.take_frac && dexp_d != DEXP_MIN) dexp_d = dexp_d - EXP_WIDTH'(1);
      end else begin
        // accumulator full: keep first dropped digit and a sticky bit
        if (!drop_d) begin
          rdig_d = digit;
          drop_d = 1'b1;
        end else if (digit != 4'd0) begin
          stk_d = 1'b1;
        end
        if (cmd_i.take_int && dexp_d != DEXP_MAX) dexp_d = dexp_d + EXP_WIDTH'(1);
      end
    end

    if (cmd_i.exp_sign) eneg_d = (ch_i == CH_MINUS);

    if (cmd_i.take_exp) begin
      if (ed10 > {4'd0, EXPD_MAX}) ed_d = EXPD_MAX;
      else ed_d = ed10[EXP_WIDTH-1:0];
    end

    if (cmd_i.prep) begin
      w_d = (mant_zero || e_tiny || e_big) ? '0 : PW'(mant_q);
      if (e_neg || e_zero) begin
        wrd_d = e_tiny ? 4'd0 : rdig_q;
        wst_d = e_tiny ? 1'b0 : stk_q;
      end else begin
        wrd_d = 4'd0;
        wst_d = 1'b0;
      end
      cnt_d = e_mag[CNT_W-1:0];
      chunk_d = '0;
      rem_d = 4'd0;
      sat_d = e_big && !mant_zero;
    end

    if (cmd_i.mul_step) begin
      w_d = (w_q << 3) + (w_q << 1);
      cnt_d = cnt_q - CNT_W'(1);
    end

    if (cmd_i.div_step) begin
      w_d = {w_q[PW-CHUNK-1:0], dq};
      rem_d = drem[3:0];
      // the previous round digit drops into the sticky bit
      if (chunk_first) wst_d = wst_q || (wrd_q != 4'd0);
      if (sts_o.chunk_last) begin
        wrd_d = drem[3:0];
        cnt_d = cnt_q - CNT_W'(1);
        chunk_d = '0;
      end else begin
        chunk_d = chunk_q + CHUNK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q <= 1'b0;
      mant_q <= '0;
      dexp_q <= '0;
      eneg_q <= 1'b0;
      ed_q <= '0;
      rdig_q <= 4'd0;
      stk_q <= 1'b0;
      drop_q <= 1'b0;
      cnt_q <= '0;
      chunk_q <= '0;
      sat_q <= 1'b0;
    end else begin
      neg_q <= neg_d;
      mant_q <= mant_d;
      dexp_q <= dexp_d;
      eneg_q <= eneg_d;
      ed_q <= ed_d;
      rdig_q <= rdig_d;
      stk_q <= stk_d;
      drop_q <= drop_d;
      cnt_q <= cnt_d;
      chunk_q <= chunk_d;
      sat_q <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    wrd_q <= wrd_d;
    wst_q <= wst_d;
    rem_q <= rem_d;
    if (cmd_i.finish) begin
      val_q <= neg_q ? (32'd0 - mag) : mag;
      satout_q <= sat_f;
    end
  end

  assign value_o = $signed(val_q);
  assign saturated_o = satout_q;

  // the carried remainder of a divide pass is always a decimal digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step && !chunk_first) |-> (rem_q <= 4'd9))
    else $error("divide remainder out of range");

endmodule

FILE: hw/rtl/decimal_text_to_rounded_integer_top.sv
`timescale 1ns / 1ps
// sequence: characters are parsed as they are transferred; after the terminating
// character transfer, a setup state, then 1..9 multiply-by-ten steps or up to 19
// divides by ten done in 16-bit slices, then a rounding state into the output register
// throughput: one character per cycle while parsing; input stalls during scaling and rounding
// reset: asynchronous, active low; clears the parser and the output valid
module decimal_text_to_rounded_integer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         ch_i,
  input  logic               start_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_o,
  output logic               saturated_o
);
  import dttri_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dttri_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .start_req_i (start_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dttri_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ch_i        (ch_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .value_o     (value_o),
    .saturated_o (saturated_o)
  );

endmodule

FILE: tb/tb_decimal_text_to_rounded_integer_top.sv
`timescale 1ns / 1ps
module tb_decimal_text_to_rounded_integer_top;
  import dttri_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned TARGET_CHARS = 1950;
  localparam int unsigned QUIET_FROM = 1700;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_X = 8'h78;
  localparam logic [7:0] CH_Z = 8'h7A;

  typedef struct {
    logic signed [31:0] value;
    logic               sat;
  } rounded_t;

  typedef struct {
    logic [7:0] code;
    logic       first;
  } text_char_t;

  // predicts the rounded integer of each parsed number and checks the block against it
  class rounded_int_scoreboard;
    localparam logic [ACC_WIDTH-1:0] MANT_FULL = ({ACC_WIDTH{1'b1}} - 9) / 10;
    localparam longint DEXP_HI = (64'sd1 <<< (EXP_WIDTH - 1)) - 1;
    localparam longint DEXP_LO = -DEXP_HI - 1;
    localparam longint unsigned EXPD_TOP = (64'd1 << EXP_WIDTH) - 1;
    localparam logic [63:0] MAG_TOP = 64'd2147483647;

    rounded_t expected_ints[$];
    int errors;

    state_e               phase;
    bit                   neg;
    logic [ACC_WIDTH-1:0] mant;
    longint               dexp;
    bit                   exp_neg;
    longint unsigned      expd;
    int unsigned          rdig;
    bit                   sticky;
    bit                   dropped;

    function new();
      errors = 0;
      clear_number();
    endfunction

    function void clear_number();
      phase = ST_IDLE;
      neg = 0;
      mant = '0;
      dexp = 0;
      exp_neg = 0;
      expd = 0;
      rdig = 0;
      sticky = 0;
      dropped = 0;
    endfunction

    function void take_digit(int unsigned d, bit in_frac);
      if (mant <= MANT_FULL) begin
        mant = mant * 10 + ACC_WIDTH'(d);
        if (in_frac && dexp > DEXP_LO) dexp--;
        return;
      end
      // accumulator full: keep the first dropped digit and a sticky of the rest
      if (!dropped) begin
        rdig = d;
        dropped = 1;
      end else if (d != 0) begin
        sticky = 1;
      end
      if (!in_frac && dexp < DEXP_HI) dexp++;
    endfunction

    // returns 0 when the block ignores the character
    function bit note_char(logic [7:0] c, logic first);
      bit          is_digit;
      int unsigned d;
      bit          ends;
      longint      e;
      logic [63:0] q;
      logic [63:0] p_lo;
      logic [63:0] p_hi;
      logic [63:0] rem;
      bit          sat;
      bit          st;
      int unsigned rd;
      int unsigned k;
      int          i;
      logic [31:0] mag;
      rounded_t    r;
      is_digit = (c >= CH_ZERO && c <= CH_NINE);
      d = is_digit ? int'(c - CH_ZERO) : 0;
      if (first) begin
        clear_number();
        phase = ST_INT;
        if (c == CH_MINUS) begin
          neg = 1;
          return 1;
        end
        if (c == CH_PLUS) return 1;
      end
      ends = 0;
      case (phase)
        ST_INT: begin
          if (is_digit) take_digit(d, 0);
          else if (c == CH_DOT) phase = ST_FRAC;
          else if (c == CH_E_LO || c == CH_E_UP) phase = ST_EXP0;
          else ends = 1;
        end
        ST_FRAC: begin
          if (is_digit) take_digit(d, 1);
          else if (c == CH_E_LO || c == CH_E_UP) phase = ST_EXP0;
          else ends = 1;
        end
        ST_EXP0, ST_EXP1: begin
          if (phase == ST_EXP0 && (c == CH_PLUS || c == CH_MINUS)) begin
            exp_neg = (c == CH_MINUS);
            phase = ST_EXP1;
          end else if (is_digit) begin
            phase = ST_EXP1;
            if (expd > (EXPD_TOP - d) / 10) expd = EXPD_TOP;
            else expd = expd * 10 + d;
          end else begin
            ends = 1;
          end
        end
        default: return 0;
      endcase
      if (!ends) return 1;

      e = exp_neg ? dexp - longint'(expd) : dexp + longint'(expd);
      q = '0;
      sat = 0;
      if (mant != 0) begin
        if (e > 0) begin
          if (e > 9) begin
            sat = 1;
          end else begin
            q = mant;
            for (i = 0; i < e && !sat; i++) begin
              if (q > MAG_TOP) sat = 1;
              else q = q * 10;
            end
            if (q > MAG_TOP) sat = 1;
          end
        end else if (e > -20) begin
          k = int'(-e);
          if (k == 0) begin
            q = mant;
            rd = rdig;
            st = sticky;
          end else begin
            p_lo = 64'd1;
            repeat (k - 1) p_lo = p_lo * 10;
            p_hi = p_lo * 10;
            rem = mant % p_hi;
            q = mant / p_hi;
            rd = int'(rem / p_lo);
            st = (rem % p_lo) != 0 || rdig != 0 || sticky;
          end
          if (q > MAG_TOP) begin
            sat = 1;
          end else begin
            // round up only when strictly above one half
            if (rd > 5 || (rd == 5 && st)) q = q + 1;
            if (q > MAG_TOP) sat = 1;
          end
        end
      end
      if (sat) q = MAG_TOP;
      mag = q[31:0];
      r.value = neg ? -mag : mag;
      r.sat = sat;
      expected_ints.push_back(r);
      clear_number();
      return 1;
    endfunction

    function void check_int(logic signed [31:0] v, logic s);
      rounded_t want;
      if (expected_ints.size() == 0) begin
        $display("%0t: unexpected result: value %0d saturated %0b", $time, v, s);
        errors++;
        return;
      end
      want = expected_ints.pop_front();
      if (v !== want.value) begin
        $display("%0t: value mismatch: expected %0d actual %0d", $time, want.value, v);
        errors++;
      end
      if (s !== want.sat) begin
        $display("%0t: saturated mismatch: expected %0b actual %0b", $time, want.sat, s);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         ch_i;
  logic               start_req_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] value_o;
  logic               saturated_o;

  rounded_int_scoreboard sb;
  text_char_t            text[$];
  int unsigned           chars_taken;
  int unsigned           cycles;
  int unsigned           stall_left;
  bit                    quiet;

  decimal_text_to_rounded_integer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .ch_i        (ch_i),
    .start_req_i (start_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .saturated_o (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_int(value_o, saturated_o);
  end

  // receiver back-pressure in short random bursts
  initial begin
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet && rst_ni && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function void push_char(logic [7:0] c, logic first);
    text_char_t t;
    t.code = c;
    t.first = first;
    text.push_back(t);
  endfunction

  function void push_str(string s);
    int i;
    for (i = 0; i < s.len(); i++) push_char(s[i], i == 0);
  endfunction

  function logic [7:0] rand_digit(bit bias_half);
    if (bias_half && $urandom_range(0, 3) == 0) return CH_ZERO + 8'd5;
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // one well-formed number with random content, sometimes cut short
  function void build_number();
    int unsigned r;
    int unsigned n;
    int unsigned j;
    r = $urandom_range(0, 2);
    push_char(r == 0 ? CH_MINUS : (r == 1 ? CH_PLUS : rand_digit(0)), 1'b1);
    r = $urandom_range(0, 99);
    n = r < 8 ? 0 : (r < 80 ? $urandom_range(1, 4) :
        (r < 92 ? $urandom_range(5, 10) : $urandom_range(18, 24)));
    for (j = 0; j < n; j++) push_char(rand_digit(0), 1'b0);
    if ($urandom_range(0, 1) == 1) begin
      push_char(CH_DOT, 1'b0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 3);
      for (j = 0; j < n; j++) push_char(rand_digit(1), 1'b0);
    end
    if ($urandom_range(0, 99) < 35) begin
      push_char($urandom_range(0, 1) ? CH_E_LO : CH_E_UP, 1'b0);
      r = $urandom_range(0, 2);
      if (r == 0) push_char(CH_MINUS, 1'b0);
      else if (r == 1) push_char(CH_PLUS, 1'b0);
      n = ($urandom_range(0, 6) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 2);
      for (j = 0; j < n; j++) push_char(rand_digit(0), 1'b0);
    end
    if ($urandom_range(0, 9) != 0) begin
      push_char($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(0, 255)), 1'b0);
    end
  endfunction

  task automatic send_text();
    text_char_t t;
    while (text.size() > 0) begin
      t = text.pop_front();
      if (!quiet && $urandom_range(0, 5) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      ch_i <= t.code;
      start_req_i <= t.first;
      do @(posedge clk_i); while (!in_ready_o);
      if (sb.note_char(t.code, t.first)) chars_taken++;
    end
  endtask

  initial begin
    int unsigned n;
    int unsigned j;
    sb = new();
    chars_taken = 0;
    quiet = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    ch_i = '0;
    start_req_i = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_str("-7 ");
    push_str("2.5 ");
    push_str("x");
    // idle character, ignored
    push_char(CH_Z, 1'b0);
    push_str("-. ");
    push_str("-0 ");
    push_str("9E9 ");
    // restart abandons the number in progress
    push_str("12");
    push_str("1e-25 ");
    send_text();

    while (chars_taken < TARGET_CHARS) begin
      if (chars_taken >= QUIET_FROM) quiet = 1;
      if ($urandom_range(0, 99) < 85) begin
        build_number();
      end else begin
        n = $urandom_range(1, 3);
        for (j = 0; j < n; j++) begin
          push_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
      end
      send_text();
    end

    // a lone non-number character abandons anything still open and ends as a zero result
    push_char(CH_X, 1'b1);
    send_text();
    in_valid_i <= 1'b0;

    while (sb.expected_ints.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
